// File: rtl/core/mmsp_pkg.sv
// ----------------------------------------------------------------------------
// Map metadata stream parser package
// Shared phase codes, result kinds, status codes, wall error codes and config indices.
// ----------------------------------------------------------------------------
`default_nettype none

package mmsp_pkg;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_VERSION, PH_RESERVED, PH_NAME_LEN, PH_NAME_CHARS,
    PH_FILE_LEN, PH_FILE_CHARS, PH_HASH_LEN, PH_HASH_CHARS, PH_WIDTH,
    PH_HEIGHT, PH_COUNT, PH_WNAME_LEN, PH_WNAME_CHARS, PH_X, PH_Y, PH_W,
    PH_H, PH_COLOUR, PH_END, PH_DEAD
  } phase_t;

  typedef enum logic [3:0] {
    K_NAME_CHAR = 4'd0, K_FILE_CHAR = 4'd1, K_HASH_CHAR = 4'd2, K_WIDTH = 4'd3,
    K_HEIGHT = 4'd4, K_COUNT = 4'd5, K_WNAME_CHAR = 4'd6, K_X = 4'd7,
    K_Y = 4'd8, K_W = 4'd9, K_H = 4'd10, K_COLOUR = 4'd11, K_NONE = 4'd12
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_SIZE = 4'd1, ST_MAGIC = 4'd2, ST_VERSION = 4'd3,
    ST_STRING = 4'd4, ST_TRUNC = 4'd5, ST_COUNT = 4'd6, ST_TRAILING = 4'd7,
    ST_DIMS = 4'd8, ST_HASH = 4'd9, ST_COORDS = 4'd10, ST_BOUNDS = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    WE_NONE = 2'd0, WE_COORDS = 2'd1, WE_BOUNDS = 2'd2
  } wall_err_t;

  localparam logic [1:0] CFG_VERSION   = 2'd0;
  localparam logic [1:0] CFG_MAX_WALLS = 2'd1;
  localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

  localparam logic [24:0] BYTES_MAX  = 25'h1FFFFFF;
  localparam logic [15:0] HASH_CHARS = 16'd64;
  localparam logic [24:0] MIN_BYTES  = 25'd8;

  // Magic byte at a given position.
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] r;
    unique case (pos)
      2'd0:    r = 8'h57;
      2'd1:    r = 8'h32;
      2'd2:    r = 8'h57;
      default: r = 8'h4D;
    endcase
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mmsp_wall_check.sv
// ----------------------------------------------------------------------------
// Wall rectangle check
// Classifies a completed wall as fine, bad coordinates or out of bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsp_wall_check (
  input  wire logic [31:0]        x,
  input  wire logic [31:0]        y,
  input  wire logic [31:0]        w,
  input  wire logic [31:0]        h,
  input  wire logic [31:0]        map_w,
  input  wire logic [31:0]        map_h,
  output mmsp_pkg::wall_err_t     err
);

  logic signed [32:0] lim_x;
  logic signed [32:0] lim_y;

  // Room left on each axis, computed one bit wider so it cannot wrap.
  assign lim_x = $signed({map_w[31], map_w}) - $signed({w[31], w});
  assign lim_y = $signed({map_h[31], map_h}) - $signed({h[31], h});

  always_comb begin
    if (x[31] || y[31] || w[31] || (w == 32'd0) || h[31] || (h == 32'd0)) begin
      err = mmsp_pkg::WE_COORDS;
    end else if ($signed({1'b0, x}) > lim_x || $signed({1'b0, y}) > lim_y) begin
      err = mmsp_pkg::WE_BOUNDS;
    end else begin
      err = mmsp_pkg::WE_NONE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/map_metadata_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// Map metadata stream parser
// Parses a little-endian map metadata payload one byte per transfer and
// emits string characters, numeric fields and a final status.
// ----------------------------------------------------------------------------
//  Channel   Signals                                        Direction
//  input     in_valid, in_stall, data_byte, last_byte       in
//  output    out_valid, out_stall, field_kind, field_value,
//            wall_number, final_flag, status                out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data      in
//
// One byte is taken per cycle; the parse state updates in that same cycle
// and a result lands in a single output register in the next cycle.
// Input is stalled only while that register holds a result that is stalled.
// Reset restores the register defaults and the start of a payload.
// ----------------------------------------------------------------------------
`default_nettype none

module map_metadata_stream_parser_unit #(
  parameter int MAX_STRING_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       field_kind,
  output logic [31:0]      field_value,
  output logic [15:0]      wall_number,
  output logic             final_flag,
  output logic [3:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [24:0] cfg_data
);

  localparam logic [15:0] STR_LIMIT = 16'(MAX_STRING_BYTES);

  logic [15:0] expected_version;
  logic [15:0] max_walls;
  logic [24:0] max_payload_bytes;

  mmsp_pkg::phase_t    parse_phase, ph_next;
  logic [1:0]          byte_in_field, bif_next;
  logic [31:0]         assembly_word, asm_next;
  logic [15:0]         string_left, sl_next;
  logic [24:0]         bytes_seen, bs_next;
  logic [15:0]         walls_expected, we_next;
  logic [15:0]         walls_done, wd_next;
  logic [31:0]         map_width_reg, mw_next;
  logic [31:0]         map_height_reg, mh_next;
  logic [31:0]         rect_x, rx_next;
  logic [31:0]         rect_y, ry_next;
  logic [31:0]         rect_w, rw_next;
  logic [15:0]         hash_length, hl_next;
  logic                hash_nonhex_seen, hn_next;
  mmsp_pkg::status_t   parse_error, pe_next;
  logic                dims_bad, db_next;
  mmsp_pkg::wall_err_t first_wall_error, fwe_next;

  logic        accept;
  logic        have;
  logic [3:0]  kind;
  logic [31:0] val;
  logic [15:0] wn;
  logic [31:0] word;
  logic        full2, full4;
  logic        hash_bad;
  mmsp_pkg::status_t   st;
  mmsp_pkg::wall_err_t wall_err;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version  <= 16'd1;
      max_walls         <= 16'd256;
      max_payload_bytes <= 25'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmsp_pkg::CFG_VERSION:   expected_version  <= cfg_data[15:0];
        mmsp_pkg::CFG_MAX_WALLS: max_walls         <= cfg_data[15:0];
        mmsp_pkg::CFG_MAX_BYTES: max_payload_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Assembled field value including this byte.
  always_comb begin
    word = assembly_word;
    unique case (byte_in_field)
      2'd0:    word[7:0]   = assembly_word[7:0]   | data_byte;
      2'd1:    word[15:8]  = assembly_word[15:8]  | data_byte;
      2'd2:    word[23:16] = assembly_word[23:16] | data_byte;
      default: word[31:24] = assembly_word[31:24] | data_byte;
    endcase
  end
  assign full2 = byte_in_field >= 2'd1;
  assign full4 = byte_in_field == 2'd3;

  mmsp_wall_check u_wall (
    .x(rect_x), .y(rect_y), .w(rect_w), .h(word),
    .map_w(map_width_reg), .map_h(map_height_reg), .err(wall_err)
  );

  // Per-byte parse step.
  always_comb begin
    logic [15:0] slen;
    logic        fail_now;
    mmsp_pkg::status_t fcode;
    mmsp_pkg::phase_t  chars_ph, after_ph;
    logic        str_start;
    slen = word[15:0];
    fail_now = 1'b0;
    fcode = mmsp_pkg::ST_OK;
    chars_ph = mmsp_pkg::PH_NAME_CHARS;
    after_ph = mmsp_pkg::PH_FILE_LEN;
    str_start = 1'b0;

    ph_next = parse_phase; bif_next = byte_in_field; asm_next = assembly_word;
    sl_next = string_left; we_next = walls_expected; wd_next = walls_done;
    mw_next = map_width_reg; mh_next = map_height_reg;
    rx_next = rect_x; ry_next = rect_y; rw_next = rect_w;
    hl_next = hash_length; hn_next = hash_nonhex_seen; pe_next = parse_error;
    db_next = dims_bad; fwe_next = first_wall_error;
    have = 1'b0; kind = mmsp_pkg::K_NONE; val = 32'd0; wn = 16'd0;

    bs_next = (bytes_seen != mmsp_pkg::BYTES_MAX) ? bytes_seen + 25'd1 : bytes_seen;
    if (bs_next > max_payload_bytes) begin
      pe_next = mmsp_pkg::ST_SIZE;
      ph_next = mmsp_pkg::PH_DEAD;
    end

    // Field assembly shared by the numeric phases.
    unique case (ph_next)
      mmsp_pkg::PH_VERSION, mmsp_pkg::PH_RESERVED, mmsp_pkg::PH_NAME_LEN,
      mmsp_pkg::PH_FILE_LEN, mmsp_pkg::PH_HASH_LEN, mmsp_pkg::PH_WNAME_LEN,
      mmsp_pkg::PH_COUNT: begin
        asm_next = full2 ? 32'd0 : word;
        bif_next = full2 ? 2'd0 : byte_in_field + 2'd1;
      end
      mmsp_pkg::PH_WIDTH, mmsp_pkg::PH_HEIGHT, mmsp_pkg::PH_X, mmsp_pkg::PH_Y,
      mmsp_pkg::PH_W, mmsp_pkg::PH_H, mmsp_pkg::PH_COLOUR: begin
        asm_next = full4 ? 32'd0 : word;
        bif_next = byte_in_field + 2'd1;
      end
      default: ;
    endcase

    unique case (ph_next)
      mmsp_pkg::PH_MAGIC: begin
        if (data_byte != mmsp_pkg::magic_byte(byte_in_field)) begin
          fail_now = 1'b1; fcode = mmsp_pkg::ST_MAGIC;
        end else if (byte_in_field == 2'd3) begin
          bif_next = 2'd0; ph_next = mmsp_pkg::PH_VERSION;
        end else begin
          bif_next = byte_in_field + 2'd1;
        end
      end
      mmsp_pkg::PH_VERSION: if (full2) begin
        if (slen != expected_version) begin
          fail_now = 1'b1; fcode = mmsp_pkg::ST_VERSION;
        end else begin
          ph_next = mmsp_pkg::PH_RESERVED;
        end
      end
      mmsp_pkg::PH_RESERVED: if (full2) ph_next = mmsp_pkg::PH_NAME_LEN;
      mmsp_pkg::PH_NAME_LEN: if (full2) begin
        str_start = 1'b1;
      end
      mmsp_pkg::PH_FILE_LEN: if (full2) begin
        str_start = 1'b1;
        chars_ph = mmsp_pkg::PH_FILE_CHARS; after_ph = mmsp_pkg::PH_HASH_LEN;
      end
      mmsp_pkg::PH_HASH_LEN: if (full2) begin
        str_start = 1'b1; hl_next = slen;
        chars_ph = mmsp_pkg::PH_HASH_CHARS; after_ph = mmsp_pkg::PH_WIDTH;
      end
      mmsp_pkg::PH_WNAME_LEN: if (full2) begin
        str_start = 1'b1;
        chars_ph = mmsp_pkg::PH_WNAME_CHARS; after_ph = mmsp_pkg::PH_X;
      end
      mmsp_pkg::PH_NAME_CHARS, mmsp_pkg::PH_FILE_CHARS,
      mmsp_pkg::PH_HASH_CHARS, mmsp_pkg::PH_WNAME_CHARS: begin
        have = 1'b1; val = {24'd0, data_byte};
        unique case (ph_next)
          mmsp_pkg::PH_NAME_CHARS: begin
            kind = mmsp_pkg::K_NAME_CHAR; after_ph = mmsp_pkg::PH_FILE_LEN;
          end
          mmsp_pkg::PH_FILE_CHARS: begin
            kind = mmsp_pkg::K_FILE_CHAR; after_ph = mmsp_pkg::PH_HASH_LEN;
          end
          mmsp_pkg::PH_HASH_CHARS: begin
            kind = mmsp_pkg::K_HASH_CHAR; after_ph = mmsp_pkg::PH_WIDTH;
            if (!mmsp_pkg::is_hex(data_byte)) hn_next = 1'b1;
          end
          default: begin
            kind = mmsp_pkg::K_WNAME_CHAR; after_ph = mmsp_pkg::PH_X; wn = walls_done;
          end
        endcase
        sl_next = (string_left != 16'd0) ? string_left - 16'd1 : 16'd0;
        if (sl_next == 16'd0) ph_next = after_ph;
      end
      mmsp_pkg::PH_WIDTH, mmsp_pkg::PH_HEIGHT: if (full4) begin
        if (word[31] || word == 32'd0) db_next = 1'b1;
        have = 1'b1; val = word;
        if (ph_next == mmsp_pkg::PH_WIDTH) begin
          mw_next = word; kind = mmsp_pkg::K_WIDTH; ph_next = mmsp_pkg::PH_HEIGHT;
        end else begin
          mh_next = word; kind = mmsp_pkg::K_HEIGHT; ph_next = mmsp_pkg::PH_COUNT;
        end
      end
      mmsp_pkg::PH_COUNT: if (full2) begin
        if (slen == 16'd0 || slen > max_walls) begin
          fail_now = 1'b1; fcode = mmsp_pkg::ST_COUNT;
        end else begin
          we_next = slen; wd_next = 16'd0; have = 1'b1;
          kind = mmsp_pkg::K_COUNT; val = word; ph_next = mmsp_pkg::PH_WNAME_LEN;
        end
      end
      mmsp_pkg::PH_X, mmsp_pkg::PH_Y, mmsp_pkg::PH_W: if (full4) begin
        have = 1'b1; val = word; wn = walls_done;
        unique case (ph_next)
          mmsp_pkg::PH_X: begin
            rx_next = word; kind = mmsp_pkg::K_X; ph_next = mmsp_pkg::PH_Y;
          end
          mmsp_pkg::PH_Y: begin
            ry_next = word; kind = mmsp_pkg::K_Y; ph_next = mmsp_pkg::PH_W;
          end
          default: begin
            rw_next = word; kind = mmsp_pkg::K_W; ph_next = mmsp_pkg::PH_H;
          end
        endcase
      end
      mmsp_pkg::PH_H: if (full4) begin
        if (first_wall_error == mmsp_pkg::WE_NONE) fwe_next = wall_err;
        have = 1'b1; kind = mmsp_pkg::K_H; val = word; wn = walls_done;
        ph_next = mmsp_pkg::PH_COLOUR;
      end
      mmsp_pkg::PH_COLOUR: if (full4) begin
        have = 1'b1; kind = mmsp_pkg::K_COLOUR; val = word; wn = walls_done;
        wd_next = walls_done + 16'd1;
        ph_next = (wd_next == walls_expected) ? mmsp_pkg::PH_END : mmsp_pkg::PH_WNAME_LEN;
      end
      mmsp_pkg::PH_END: begin
        fail_now = 1'b1; fcode = mmsp_pkg::ST_TRAILING;
      end
      default: ;
    endcase

    // Start of a length-prefixed string.
    if (str_start) begin
      if (slen > STR_LIMIT) begin
        fail_now = 1'b1; fcode = mmsp_pkg::ST_STRING;
      end else if (slen == 16'd0) begin
        ph_next = after_ph;
      end else begin
        sl_next = slen; ph_next = chars_ph;
      end
    end

    if (fail_now) begin
      if (pe_next == mmsp_pkg::ST_OK) pe_next = fcode;
      ph_next = mmsp_pkg::PH_DEAD;
      bif_next = 2'd0;
    end

    hash_bad = hn_next || (hl_next != 16'd0 && hl_next != mmsp_pkg::HASH_CHARS);
    if (pe_next != mmsp_pkg::ST_OK || db_next || hash_bad ||
        fwe_next != mmsp_pkg::WE_NONE) begin
      have = 1'b0;
    end

    // Final status.
    if (bs_next < mmsp_pkg::MIN_BYTES || pe_next == mmsp_pkg::ST_SIZE)
      st = mmsp_pkg::ST_SIZE;
    else if (pe_next != mmsp_pkg::ST_OK)      st = pe_next;
    else if (ph_next != mmsp_pkg::PH_END)     st = mmsp_pkg::ST_TRUNC;
    else if (db_next)                         st = mmsp_pkg::ST_DIMS;
    else if (hash_bad)                        st = mmsp_pkg::ST_HASH;
    else if (fwe_next == mmsp_pkg::WE_COORDS) st = mmsp_pkg::ST_COORDS;
    else if (fwe_next == mmsp_pkg::WE_BOUNDS) st = mmsp_pkg::ST_BOUNDS;
    else                                      st = mmsp_pkg::ST_OK;
  end

  // Parse state; the last byte starts a fresh payload.
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      parse_phase <= mmsp_pkg::PH_MAGIC; byte_in_field <= 2'd0;
      assembly_word <= 32'd0; string_left <= 16'd0; bytes_seen <= 25'd0;
      walls_expected <= 16'd0; walls_done <= 16'd0;
      map_width_reg <= 32'd0; map_height_reg <= 32'd0;
      rect_x <= 32'd0; rect_y <= 32'd0; rect_w <= 32'd0;
      hash_length <= 16'd0; hash_nonhex_seen <= 1'b0;
      parse_error <= mmsp_pkg::ST_OK; dims_bad <= 1'b0;
      first_wall_error <= mmsp_pkg::WE_NONE;
    end else if (accept) begin
      parse_phase <= ph_next; byte_in_field <= bif_next;
      assembly_word <= asm_next; string_left <= sl_next; bytes_seen <= bs_next;
      walls_expected <= we_next; walls_done <= wd_next;
      map_width_reg <= mw_next; map_height_reg <= mh_next;
      rect_x <= rx_next; rect_y <= ry_next; rect_w <= rw_next;
      hash_length <= hl_next; hash_nonhex_seen <= hn_next;
      parse_error <= pe_next; dims_bad <= db_next;
      first_wall_error <= fwe_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= accept && (have || last_byte);
      if (last_byte && (!have || st != mmsp_pkg::ST_OK)) begin
        field_kind <= mmsp_pkg::K_NONE; field_value <= 32'd0; wall_number <= 16'd0;
      end else begin
        field_kind <= kind; field_value <= val; wall_number <= wn;
      end
      final_flag <= last_byte;
      status     <= last_byte ? st : mmsp_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire
